// ===== sv/ssca_pkg.sv =====
package ssca_pkg;

   localparam int ADDR_W      = 18;
   localparam int SIZE_W      = 12;
   localparam int STATUS_W    = 2;
   localparam int CLASS_W     = 4;
   localparam int BYTES_W     = 12;
   localparam int CLASS_COUNT = 9;
   localparam int POOL_PAGES  = 64;
   localparam int PAGE_BYTES  = 4096;
   localparam int HDR_BYTES   = 16;
   localparam int USABLE      = PAGE_BYTES - HDR_BYTES;
   localparam int SLOT_W      = 8;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_PAGES  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [SIZE_W-1:0] req_size;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   granted_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // bytes per block of a class, the top class holds one block of all usable bytes of a page
   function automatic logic [BYTES_W-1:0] block_bytes(input logic [CLASS_W-1:0] c);
      logic [BYTES_W-1:0] r;
      if (c >= CLASS_W'(CLASS_COUNT - 1)) r = BYTES_W'(USABLE);
      else r = BYTES_W'(16) << c;
      return r;
   endfunction

   // usable bytes of a page carved into one class
   function automatic logic [BYTES_W-1:0] page_capacity(input logic [CLASS_W-1:0] c);
      logic [BYTES_W-1:0] r;
      unique case (c)
         4'd0:    r = BYTES_W'(4080);
         4'd1:    r = BYTES_W'(4064);
         4'd2:    r = BYTES_W'(4032);
         4'd3:    r = BYTES_W'(3968);
         4'd4:    r = BYTES_W'(3840);
         4'd5:    r = BYTES_W'(3584);
         4'd6:    r = BYTES_W'(3072);
         4'd7:    r = BYTES_W'(2048);
         default: r = BYTES_W'(USABLE);
      endcase
      return r;
   endfunction

   // smallest power-of-two class that fits the request
   function automatic logic [CLASS_W-1:0] size_class(input logic [SIZE_W-1:0] s);
      logic [CLASS_W-1:0] r;
      r = CLASS_W'(CLASS_COUNT - 1);
      for (int i = CLASS_COUNT - 2; i >= 0; i--) begin
         if ((13'd16 << i) >= {1'b0, s}) r = CLASS_W'(i);
      end
      return r;
   endfunction

endpackage

// ===== sv/slab_size_class_allocator_unit.sv =====
// Slab allocator over a pool of 4 KiB pages, one transaction at a time.
// Pulse start while busy is low; one result appears on rsp_data with
// rsp_strobe high for a single cycle and must be taken then. An allocation
// from a non-empty class list pops the head of that list; an empty list
// first scans for an unused page and carves it into blocks of the class.
// A free walks its class list to catch a double free, and a free that
// empties its page walks the list once more to drop that page's entries.
// Every list walk uses the single read port of the link memory.
module slab_size_class_allocator_unit #(
   parameter int POOL_PAGES = ssca_pkg::POOL_PAGES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ssca_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ssca_pkg::rsp_type rsp_data
);

   localparam int PAGE_W     = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int BLK_W      = PAGE_W + ssca_pkg::SLOT_W;
   localparam int LINK_DEPTH = POOL_PAGES * 256;
   localparam int CW         = ssca_pkg::CLASS_W;
   localparam int BW         = ssca_pkg::BYTES_W;
   localparam int AW         = ssca_pkg::ADDR_W;
   localparam int PE_W       = CW + BW;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_A_CLASS = 4'd1;
   localparam logic [3:0] S_A_SCAN  = 4'd2;
   localparam logic [3:0] S_CARVE   = 4'd3;
   localparam logic [3:0] S_A_POP   = 4'd4;
   localparam logic [3:0] S_A_TAKE  = 4'd5;
   localparam logic [3:0] S_F_CHECK = 4'd6;
   localparam logic [3:0] S_F_PAGE  = 4'd7;
   localparam logic [3:0] S_F_WALK  = 4'd8;
   localparam logic [3:0] S_F_WAIT  = 4'd9;
   localparam logic [3:0] S_U_WALK  = 4'd10;
   localparam logic [3:0] S_U_WAIT  = 4'd11;

   logic [3:0]              state_ff, state_in;
   ssca_pkg::req_type       req_ff, req_in;
   logic [CW-1:0]           cls_ff, cls_in;
   logic [PAGE_W-1:0]       pg_ff, pg_in;
   logic [BW-1:0]           off_ff, off_in;
   logic [BW-1:0]           free_ff, free_in;
   logic [BLK_W-1:0]        cur_ff, cur_in;
   logic [BLK_W-1:0]        prev_ff, prev_in;
   logic [BLK_W-1:0]        heads_ff [ssca_pkg::CLASS_COUNT];
   logic [BLK_W-1:0]        heads_in [ssca_pkg::CLASS_COUNT];
   logic [POOL_PAGES-1:0]   in_use_ff, in_use_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   ssca_pkg::rsp_type       rsp_ff, rsp_in;

   // link memory and page table
   logic [BLK_W-1:0]  link_mem [LINK_DEPTH];
   logic [BLK_W-1:0]  link_q;
   logic              link_we;
   logic [BLK_W-1:0]  link_waddr, link_wdata, link_raddr;
   logic [PE_W-1:0]   page_mem [POOL_PAGES];
   logic [PE_W-1:0]   page_q;
   logic              page_we;
   logic [PAGE_W-1:0] page_waddr, page_raddr;
   logic [PE_W-1:0]   page_wdata;

   logic [BLK_W-1:0]  head_cur;
   logic [BW-1:0]     bs, cap;
   logic [BW:0]       carve_end;
   logic [5:0]        addr_page;
   logic [BW-1:0]     addr_off, off_rel;
   logic [BLK_W-1:0]  free_blk;
   logic [BW-1:0]     q_free;
   logic [CW-1:0]     q_cls;
   logic [BW-1:0]     q_bs, q_cap;
   logic [BW:0]       q_sum;
   logic              bad_free;

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      link_q <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (page_we) page_mem[page_waddr] <= page_wdata;
      page_q <= page_mem[page_raddr];
   end

   // decoded operands
   always_comb begin
      head_cur  = heads_ff[cls_ff];
      bs        = ssca_pkg::block_bytes(cls_ff);
      cap       = ssca_pkg::page_capacity(cls_ff);
      carve_end = {1'b0, off_ff} + {1'b0, bs};
      addr_page = req_ff.block_address[AW-1:12];
      addr_off  = req_ff.block_address[11:0];
      off_rel   = addr_off - BW'(ssca_pkg::HDR_BYTES);
      free_blk  = {pg_ff, addr_off[11:4]};
      q_cls     = page_q[PE_W-1:BW];
      q_free    = page_q[BW-1:0];
      q_bs      = ssca_pkg::block_bytes(q_cls);
      q_cap     = ssca_pkg::page_capacity(q_cls);
      q_sum     = {1'b0, q_free} + {1'b0, q_bs};
      bad_free  = (q_cls >= CW'(ssca_pkg::CLASS_COUNT))
               || (addr_off < BW'(ssca_pkg::HDR_BYTES))
               || ((q_cls < CW'(ssca_pkg::CLASS_COUNT - 1))
                   ? ((off_rel & (q_bs - BW'(1))) != '0) : (off_rel != '0))
               || (off_rel >= q_cap)
               || (q_sum > {1'b0, q_cap});
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cls_in        = cls_ff;
      pg_in         = pg_ff;
      off_in        = off_ff;
      free_in       = free_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      heads_in      = heads_ff;
      in_use_in     = in_use_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      link_we       = 1'b0;
      link_waddr    = cur_ff;
      link_wdata    = head_cur;
      link_raddr    = (state_ff == S_A_POP) ? head_cur : cur_ff;
      page_we       = 1'b0;
      page_waddr    = pg_ff;
      page_wdata    = {cls_ff, free_ff};
      page_raddr    = pg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = (req_data.kind == ssca_pkg::KIND_FREE) ? S_F_CHECK : S_A_CLASS;
            end
         end
         S_A_CLASS: begin
            cls_in = ssca_pkg::size_class(req_ff.req_size);
            pg_in  = '0;
            if (req_ff.req_size >= ssca_pkg::SIZE_W'(ssca_pkg::USABLE)) begin
               rsp_in        = '{granted_address: '0, status: ssca_pkg::ST_TOO_LARGE};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (heads_ff[ssca_pkg::size_class(req_ff.req_size)] != '0) begin
               state_in = S_A_POP;
            end else begin
               state_in = S_A_SCAN;
            end
         end
         S_A_SCAN: begin
            if (!in_use_ff[pg_ff]) begin
               in_use_in[pg_ff] = 1'b1;
               page_we          = 1'b1;
               page_wdata       = {cls_ff, cap};
               off_in           = '0;
               state_in         = S_CARVE;
            end else if (pg_ff == PAGE_W'(POOL_PAGES - 1)) begin
               rsp_in        = '{granted_address: '0, status: ssca_pkg::ST_NO_PAGES};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               pg_in = pg_ff + PAGE_W'(1);
            end
         end
         S_CARVE: begin
            // push blocks in rising address order
            if (carve_end <= {1'b0, cap}) begin
               link_we          = 1'b1;
               link_waddr       = {pg_ff, off_ff[11:4] + 8'd1};
               heads_in[cls_ff] = {pg_ff, off_ff[11:4] + 8'd1};
               off_in           = carve_end[BW-1:0];
            end else begin
               state_in = S_A_POP;
            end
         end
         S_A_POP: begin
            cur_in     = head_cur;
            page_raddr = head_cur[BLK_W-1:ssca_pkg::SLOT_W];
            state_in   = S_A_TAKE;
         end
         S_A_TAKE: begin
            heads_in[cls_ff] = link_q;
            page_we          = 1'b1;
            page_waddr       = cur_ff[BLK_W-1:ssca_pkg::SLOT_W];
            page_wdata       = {q_cls, (q_free >= bs) ? q_free - bs : BW'(0)};
            rsp_in           = '{granted_address: AW'({cur_ff, 4'b0000}),
                                 status: ssca_pkg::ST_OK};
            rsp_strobe_in    = 1'b1;
            state_in         = S_IDLE;
         end
         S_F_CHECK: begin
            pg_in = PAGE_W'(addr_page);
            if ((32'(addr_page) >= POOL_PAGES) || !in_use_ff[PAGE_W'(addr_page)]) begin
               rsp_in        = '{granted_address: '0, status: ssca_pkg::ST_BAD_FREE};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               page_raddr = PAGE_W'(addr_page);
               state_in   = S_F_PAGE;
            end
         end
         S_F_PAGE: begin
            cls_in  = q_cls;
            free_in = q_sum[BW-1:0];
            if (bad_free) begin
               rsp_in        = '{granted_address: '0, status: ssca_pkg::ST_BAD_FREE};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cur_in   = heads_ff[q_cls];
               state_in = S_F_WALK;
            end
         end
         S_F_WALK: begin
            // double free search
            if (cur_ff == '0) begin
               page_we = 1'b1;
               if (free_ff == cap) begin
                  prev_in  = '0;
                  cur_in   = head_cur;
                  state_in = S_U_WALK;
               end else begin
                  link_we          = 1'b1;
                  link_waddr       = free_blk;
                  heads_in[cls_ff] = free_blk;
                  rsp_in           = '{granted_address: '0, status: ssca_pkg::ST_OK};
                  rsp_strobe_in    = 1'b1;
                  state_in         = S_IDLE;
               end
            end else if (cur_ff == free_blk) begin
               rsp_in        = '{granted_address: '0, status: ssca_pkg::ST_BAD_FREE};
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_F_WAIT;
            end
         end
         S_F_WAIT: begin
            cur_in   = link_q;
            state_in = S_F_WALK;
         end
         S_U_WALK: begin
            if (cur_ff == '0) begin
               in_use_in[pg_ff] = 1'b0;
               rsp_in           = '{granted_address: '0, status: ssca_pkg::ST_OK};
               rsp_strobe_in    = 1'b1;
               state_in         = S_IDLE;
            end else begin
               state_in = S_U_WAIT;
            end
         end
         S_U_WAIT: begin
            // drop entries of the released page
            if (cur_ff[BLK_W-1:ssca_pkg::SLOT_W] == pg_ff) begin
               if (prev_ff == '0) begin
                  heads_in[cls_ff] = link_q;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff;
                  link_wdata = link_q;
               end
            end else begin
               prev_in = cur_ff;
            end
            cur_in   = link_q;
            state_in = S_U_WALK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         in_use_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < ssca_pkg::CLASS_COUNT; i++) heads_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         in_use_ff     <= in_use_in;
         rsp_strobe_ff <= rsp_strobe_in;
         heads_ff      <= heads_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      cls_ff  <= cls_in;
      pg_ff   <= pg_in;
      off_ff  <= off_in;
      free_ff <= free_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");
   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still working");
   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ssca_pkg::ST_OK) |-> rsp_data.granted_address == '0)
      else $error("failed transaction returned an address");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results for one transaction");
`endif

endmodule
